FILE: hw/rtl/lcf_pkg.sv
package lcf_pkg;

  localparam int unsigned ScoreW = 7;
  localparam int unsigned RunW   = 8;
  localparam int unsigned ErrW   = 6;

  localparam logic [ScoreW-1:0] ScoreMax    = 7'd100;
  localparam logic [RunW-1:0]   RunMax      = 8'd255;
  localparam logic [ScoreW-1:0] StepUp      = 7'd4;
  localparam logic [ScoreW-1:0] StepDown    = 7'd8;
  localparam logic [ScoreW-1:0] SyncHitAdd  = 7'd12;
  localparam logic [ScoreW-1:0] SyncMissSub = 7'd6;
  localparam logic [ScoreW-1:0] MacAdd      = 7'd20;
  localparam logic [ScoreW-1:0] IschAdd     = 7'd8;
  localparam logic [ScoreW-1:0] VoiceAdd    = 7'd4;
  localparam logic [ScoreW-1:0] FailSub     = 7'd6;
  localparam logic [ScoreW-1:0] ColdLimit   = 7'd20;
  localparam logic [ScoreW-1:0] AcqLimit    = 7'd25;
  localparam logic [ScoreW-1:0] HardLimit   = 7'd60;
  localparam logic [RunW-1:0]   MissLimit   = 8'd6;
  localparam logic [ErrW-1:0]   SyncThrRst  = 6'd4;

  typedef enum logic [2:0] {
    KIND_CARRIER  = 3'd0,
    KIND_TIMING   = 3'd1,
    KIND_SYNC     = 3'd2,
    KIND_EVIDENCE = 3'd3,
    KIND_FAILURE  = 3'd4,
    KIND_LOST     = 3'd5
  } kind_e;

  // lock state, held one-hot
  typedef enum logic [5:0] {
    LS_COLD     = 6'b000001,
    LS_ACQ_TIM  = 6'b000010,
    LS_ACQ_MAP  = 6'b000100,
    LS_RECOVER  = 6'b001000,
    LS_TRK_SOFT = 6'b010000,
    LS_TRK_HARD = 6'b100000
  } lock_state_e;

  localparam logic [2:0] CodeCold    = 3'd0;
  localparam logic [2:0] CodeAcqTim  = 3'd1;
  localparam logic [2:0] CodeAcqMap  = 3'd2;
  localparam logic [2:0] CodeRecover = 3'd3;
  localparam logic [2:0] CodeTrkSoft = 3'd4;
  localparam logic [2:0] CodeTrkHard = 3'd5;

  typedef struct packed {
    logic [2:0]      kind;
    logic            stable;
    logic [ErrW-1:0] sync_errors;
    logic            mac_crc_ok;
    logic            isch_ok;
    logic            voice_ok;
  } lcf_event_t;

  typedef struct packed {
    logic [ScoreW-1:0] carrier;
    logic [ScoreW-1:0] timing;
    logic [ScoreW-1:0] sync;
    logic [ScoreW-1:0] protocol;
    logic [RunW-1:0]   miss_run;
    logic [RunW-1:0]   fail_run;
    lock_state_e       lock;
  } lcf_state_t;

  typedef struct packed {
    logic [2:0]      lock_state;
    logic [2:0]      max_timing_phases;
    logic [3:0]      max_mapping_candidates;
    logic            full_grid_allowed;
    logic [RunW-1:0] protocol_failure_run;
  } lcf_result_t;

  function automatic logic [ScoreW-1:0] sat_add(input logic [ScoreW-1:0] v,
                                                input logic [ScoreW-1:0] d);
    logic [ScoreW:0] s;
    s = {1'b0, v} + {1'b0, d};
    return (s > {1'b0, ScoreMax}) ? ScoreMax : s[ScoreW-1:0];
  endfunction

  function automatic logic [ScoreW-1:0] sat_sub(input logic [ScoreW-1:0] v,
                                                input logic [ScoreW-1:0] d);
    return (v > d) ? (v - d) : '0;
  endfunction

  function automatic logic [RunW-1:0] run_inc(input logic [RunW-1:0] v);
    return (v == RunMax) ? RunMax : (v + 1'b1);
  endfunction

endpackage

FILE: hw/rtl/lcf_in_stage.sv
module lcf_in_stage
  import lcf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lcf_event_t in_event_i,
  input  logic       take_i,      // downstream consumes the held word
  output logic       held_valid_o,
  output lcf_event_t held_event_o
);

  logic       valid_q, valid_d;
  lcf_event_t event_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      event_q <= in_event_i;
    end
  end

  assign held_valid_o = valid_q;
  assign held_event_o = event_q;

endmodule

FILE: hw/rtl/lcf_update.sv
module lcf_update
  import lcf_pkg::*;
(
  input  lcf_event_t      event_i,
  input  lcf_state_t      state_i,
  input  logic [ErrW-1:0] sync_thr_i,
  output lcf_state_t      state_o,
  output lcf_result_t     result_o
);

  lcf_state_t  upd;
  lock_state_e picked;
  logic        rescore;

  // score and run updates
  always_comb begin
    upd     = state_i;
    rescore = 1'b1;
    case (event_i.kind)
      KIND_CARRIER: begin
        upd.carrier = event_i.stable ? sat_add(state_i.carrier, StepUp)
                                     : sat_sub(state_i.carrier, StepDown);
      end
      KIND_TIMING: begin
        upd.timing = event_i.stable ? sat_add(state_i.timing, StepUp)
                                    : sat_sub(state_i.timing, StepDown);
      end
      KIND_SYNC: begin
        if (event_i.sync_errors <= sync_thr_i) begin
          upd.sync     = sat_add(state_i.sync, SyncHitAdd);
          upd.miss_run = '0;
        end else begin
          upd.sync     = sat_sub(state_i.sync, SyncMissSub);
          upd.miss_run = run_inc(state_i.miss_run);
        end
      end
      KIND_EVIDENCE: begin
        // each step caps at the max, so chaining the adds matches one capped sum
        if (event_i.mac_crc_ok) upd.protocol = sat_add(upd.protocol, MacAdd);
        if (event_i.isch_ok)    upd.protocol = sat_add(upd.protocol, IschAdd);
        if (event_i.voice_ok)   upd.protocol = sat_add(upd.protocol, VoiceAdd);
        if (event_i.mac_crc_ok || event_i.isch_ok || event_i.voice_ok) begin
          upd.fail_run = '0;
        end
      end
      KIND_FAILURE: begin
        upd.protocol = sat_sub(state_i.protocol, FailSub);
        upd.fail_run = run_inc(state_i.fail_run);
      end
      KIND_LOST: begin
        upd     = '{default: '0, lock: LS_COLD};
        rescore = 1'b0;
      end
      default: begin
        rescore = 1'b0;
      end
    endcase
  end

  // priority of threshold tests
  always_comb begin
    if (upd.carrier < ColdLimit || upd.timing < ColdLimit) begin
      picked = LS_COLD;
    end else if (upd.miss_run >= MissLimit) begin
      picked = LS_RECOVER;
    end else if (upd.sync < AcqLimit) begin
      picked = LS_ACQ_TIM;
    end else if (upd.protocol < AcqLimit) begin
      picked = LS_ACQ_MAP;
    end else if (upd.protocol >= HardLimit && upd.sync >= HardLimit) begin
      picked = LS_TRK_HARD;
    end else begin
      picked = LS_TRK_SOFT;
    end
  end

  always_comb begin
    state_o = upd;
    if (rescore) begin
      state_o.lock = picked;
    end
  end

  always_comb begin
    result_o.protocol_failure_run = state_o.fail_run;
    unique case (state_o.lock)
      LS_COLD: begin
        result_o.lock_state = CodeCold;
        result_o.max_timing_phases = 3'd6;
        result_o.max_mapping_candidates = 4'd0;
        result_o.full_grid_allowed = 1'b1;
      end
      LS_ACQ_TIM: begin
        result_o.lock_state = CodeAcqTim;
        result_o.max_timing_phases = 3'd6;
        result_o.max_mapping_candidates = 4'd0;
        result_o.full_grid_allowed = 1'b1;
      end
      LS_ACQ_MAP: begin
        result_o.lock_state = CodeAcqMap;
        result_o.max_timing_phases = 3'd4;
        result_o.max_mapping_candidates = 4'd0;
        result_o.full_grid_allowed = 1'b1;
      end
      LS_RECOVER: begin
        result_o.lock_state = CodeRecover;
        result_o.max_timing_phases = 3'd3;
        result_o.max_mapping_candidates = 4'd8;
        result_o.full_grid_allowed = 1'b0;
      end
      LS_TRK_SOFT: begin
        result_o.lock_state = CodeTrkSoft;
        result_o.max_timing_phases = 3'd2;
        result_o.max_mapping_candidates = 4'd2;
        result_o.full_grid_allowed = 1'b0;
      end
      LS_TRK_HARD: begin
        result_o.lock_state = CodeTrkHard;
        result_o.max_timing_phases = 3'd1;
        result_o.max_mapping_candidates = 4'd1;
        result_o.full_grid_allowed = 1'b0;
      end
      default: begin
        result_o.lock_state = CodeCold;
        result_o.max_timing_phases = 3'd6;
        result_o.max_mapping_candidates = 4'd0;
        result_o.full_grid_allowed = 1'b1;
      end
    endcase
  end

endmodule

FILE: hw/rtl/demod_lock_confidence_fsm.sv
// Channel   | Dir | Payload
// s_axis    | in  | tuser = kind[2:0]; tdata = stable, sync_errors, mac_crc_ok, isch_ok, voice_ok
// m_axis    | out | tdata = lock_state, max_timing_phases, max_mapping_candidates,
//           |     |         full_grid_allowed, protocol_failure_run
// cfg       | in  | cfg_we_i / cfg_wdata_i = sync_error_threshold (6 bits)
//
// One word per cycle sustained while m_axis is ready; a result passes from its word
// through the input register, then the scoring update into the result register.
// The scores, run counters and lock state update straight from the input register,
// so back-to-back words see each other's effect with no bubble.
// Reset clears scores, counters and both valids; state is Cold, threshold is 4.
// A stall on m_axis holds the result; the input register still takes one more word.
module demod_lock_confidence_fsm
  import lcf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // config
  input  logic        cfg_we_i,
  input  logic [5:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  input  logic [15:0] s_axis_tdata,   // [0] stable, [6:1] sync_errors, [7] mac_crc_ok,
                                      // [8] isch_ok, [9] voice_ok, [15:10] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [2:0] lock_state, [5:3] max_timing_phases,
                                      // [9:6] max_mapping_candidates,
                                      // [10] full_grid_allowed,
                                      // [18:11] protocol_failure_run, [23:19] zero
);

  logic [ErrW-1:0] sync_thr_q;

  lcf_event_t  in_event;
  lcf_event_t  held_event;
  logic        held_valid;
  logic        advance;

  lcf_state_t  state_q, state_d;
  lcf_result_t result_d, result_q;
  logic        out_valid_q, out_valid_d;

  assign in_event = '{
    kind:        s_axis_tuser,
    stable:      s_axis_tdata[0],
    sync_errors: s_axis_tdata[6:1],
    mac_crc_ok:  s_axis_tdata[7],
    isch_ok:     s_axis_tdata[8],
    voice_ok:    s_axis_tdata[9]
  };

  // the held word moves on when the result slot is empty or being drained
  assign advance = held_valid && (!out_valid_q || m_axis_tready);

  lcf_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_event_i   (in_event),
    .take_i       (advance),
    .held_valid_o (held_valid),
    .held_event_o (held_event)
  );

  lcf_update u_update (
    .event_i    (held_event),
    .state_i    (state_q),
    .sync_thr_i (sync_thr_q),
    .state_o    (state_d),
    .result_o   (result_d)
  );

  assign out_valid_d = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_thr_q  <= SyncThrRst;
      state_q     <= '{default: '0, lock: LS_COLD};
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sync_thr_q <= cfg_wdata_i;
      end
      if (advance) begin
        state_q <= state_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0,
                          result_q.protocol_failure_run,
                          result_q.full_grid_allowed,
                          result_q.max_mapping_candidates,
                          result_q.max_timing_phases,
                          result_q.lock_state};

  // fully-lost word clears every score and counter
  a_lost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && held_event.kind == KIND_LOST) |=>
      (state_q.carrier == '0 && state_q.timing == '0 && state_q.sync == '0 &&
       state_q.protocol == '0 && state_q.miss_run == '0 && state_q.fail_run == '0 &&
       state_q.lock == LS_COLD))
    else $error("fully-lost event did not clear state");

  // hard tracking needs both sync and protocol confidence
  a_hard_scores: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.lock == LS_TRK_HARD) |->
      (state_q.sync >= HardLimit && state_q.protocol >= HardLimit))
    else $error("tracking hard without enough confidence");

  // a stalled result freezes the supervisor state
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> $stable(state_q))
    else $error("state moved while result stalled");

  // scores never pass the cap
  a_score_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (state_q.carrier <= ScoreMax && state_q.timing <= ScoreMax &&
                 state_q.sync <= ScoreMax && state_q.protocol <= ScoreMax))
    else $error("score above cap");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lcf_pkg::*;

  // kind codes outside the defined set; the block must ignore them
  localparam logic [2:0] KindUndefLo = 3'd6;
  localparam logic [2:0] KindUndefHi = 3'd7;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [5:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser;   // [2:0] kind
  logic [15:0] s_axis_tdata;   // [0] stable, [6:1] sync_errors, [7] mac_crc_ok,
                               // [8] isch_ok, [9] voice_ok, [15:10] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [2:0] lock_state, [5:3] max_timing_phases,
                               // [9:6] max_mapping_candidates, [10] full_grid_allowed,
                               // [18:11] protocol_failure_run, [23:19] zero

  // knobs shared between the sequence and the sink process
  bit src_idle_en   = 1'b1;
  bit sink_stall_en = 1'b1;
  int hold_off_req  = 0;

  int unsigned mismatch_count = 0;

  // predicted lock supervisor state, mirrors the block after each accepted word
  logic [ScoreW-1:0] carrier_q   = '0;
  logic [ScoreW-1:0] timing_q    = '0;
  logic [ScoreW-1:0] sync_q      = '0;
  logic [ScoreW-1:0] proto_q     = '0;
  logic [RunW-1:0]   miss_run_q  = '0;
  logic [RunW-1:0]   fail_run_q  = '0;
  logic [2:0]        lock_q      = CodeCold;
  logic [ErrW-1:0]   sync_thr_q  = SyncThrRst;

  // predicted result words, oldest first
  lcf_result_t lock_expect_q[$];

  demod_lock_confidence_fsm u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop; far beyond the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic [ScoreW-1:0] score_raise(input logic [ScoreW-1:0] v,
                                                    input logic [ScoreW-1:0] d);
    int sum;
    sum = int'(v) + int'(d);
    return (sum > int'(ScoreMax)) ? ScoreMax : ScoreW'(sum);
  endfunction

  function automatic logic [ScoreW-1:0] score_lower(input logic [ScoreW-1:0] v,
                                                    input logic [ScoreW-1:0] d);
    int diff;
    diff = int'(v) - int'(d);
    return (diff < 0) ? '0 : ScoreW'(diff);
  endfunction

  function automatic logic [RunW-1:0] run_bump(input logic [RunW-1:0] v);
    return (int'(v) >= int'(RunMax)) ? RunMax : RunW'(int'(v) + 1);
  endfunction

  // threshold ladder, first match wins
  function automatic logic [2:0] pick_lock_code();
    if (carrier_q < ColdLimit || timing_q < ColdLimit) return CodeCold;
    if (miss_run_q >= MissLimit) return CodeRecover;
    if (sync_q < AcqLimit) return CodeAcqTim;
    if (proto_q < AcqLimit) return CodeAcqMap;
    if (proto_q >= HardLimit && sync_q >= HardLimit) return CodeTrkHard;
    return CodeTrkSoft;
  endfunction

  // apply one accepted event and queue the result word it must produce
  task automatic step_lock_model(input logic [2:0] kind, input logic stable,
                                 input logic [ErrW-1:0] errs, input logic mac,
                                 input logic isch, input logic voice);
    lcf_result_t want;
    case (kind)
      KIND_CARRIER: begin
        carrier_q = stable ? score_raise(carrier_q, StepUp) : score_lower(carrier_q, StepDown);
      end
      KIND_TIMING: begin
        timing_q = stable ? score_raise(timing_q, StepUp) : score_lower(timing_q, StepDown);
      end
      KIND_SYNC: begin
        if (errs <= sync_thr_q) begin
          sync_q     = score_raise(sync_q, SyncHitAdd);
          miss_run_q = '0;
        end else begin
          sync_q     = score_lower(sync_q, SyncMissSub);
          miss_run_q = run_bump(miss_run_q);
        end
      end
      KIND_EVIDENCE: begin
        if (mac) proto_q = score_raise(proto_q, MacAdd);
        if (isch) proto_q = score_raise(proto_q, IschAdd);
        if (voice) proto_q = score_raise(proto_q, VoiceAdd);
        if (mac || isch || voice) fail_run_q = '0;
      end
      KIND_FAILURE: begin
        proto_q    = score_lower(proto_q, FailSub);
        fail_run_q = run_bump(fail_run_q);
      end
      KIND_LOST: begin
        carrier_q  = '0;
        timing_q   = '0;
        sync_q     = '0;
        proto_q    = '0;
        miss_run_q = '0;
        fail_run_q = '0;
        lock_q     = CodeCold;
      end
      default: begin
        // undefined kind: nothing moves, the word just reports the state
      end
    endcase
    // the ladder runs on every scoring event, even evidence with no flags
    if (kind < KIND_LOST) lock_q = pick_lock_code();

    want.lock_state           = lock_q;
    want.full_grid_allowed    = (lock_q <= CodeAcqMap);
    want.protocol_failure_run = fail_run_q;
    case (lock_q)
      CodeCold, CodeAcqTim: begin
        want.max_timing_phases      = 3'd6;
        want.max_mapping_candidates = 4'd0;
      end
      CodeAcqMap: begin
        want.max_timing_phases      = 3'd4;
        want.max_mapping_candidates = 4'd0;
      end
      CodeRecover: begin
        want.max_timing_phases      = 3'd3;
        want.max_mapping_candidates = 4'd8;
      end
      CodeTrkSoft: begin
        want.max_timing_phases      = 3'd2;
        want.max_mapping_candidates = 4'd2;
      end
      default: begin
        want.max_timing_phases      = 3'd1;
        want.max_mapping_candidates = 4'd1;
      end
    endcase
    lock_expect_q.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("%0t: mismatch on %s, got %0d want %0d", $realtime, what, got, want);
  endtask

  // every word leaving m_axis is matched against the oldest prediction
  always @(posedge clk_i) begin : result_check
    lcf_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lock_expect_q.size() == 0) begin
        report_mismatch("unexpected result word", int'(m_axis_tdata), -1);
      end else begin
        want = lock_expect_q.pop_front();
        if (m_axis_tdata[2:0] !== want.lock_state)
          report_mismatch("lock_state", m_axis_tdata[2:0], want.lock_state);
        if (m_axis_tdata[5:3] !== want.max_timing_phases)
          report_mismatch("max_timing_phases", m_axis_tdata[5:3], want.max_timing_phases);
        if (m_axis_tdata[9:6] !== want.max_mapping_candidates)
          report_mismatch("max_mapping_candidates", m_axis_tdata[9:6],
                          want.max_mapping_candidates);
        if (m_axis_tdata[10] !== want.full_grid_allowed)
          report_mismatch("full_grid_allowed", m_axis_tdata[10], want.full_grid_allowed);
        if (m_axis_tdata[18:11] !== want.protocol_failure_run)
          report_mismatch("protocol_failure_run", m_axis_tdata[18:11],
                          want.protocol_failure_run);
        if (m_axis_tdata[23:19] !== 5'd0)
          report_mismatch("tdata padding", m_axis_tdata[23:19], 0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int gap;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req > 0) begin
        // long stall counted here; the sender keeps offering words meanwhile
        gap = hold_off_req;
        hold_off_req = 0;
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else if (sink_stall_en && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one event word; returns right after the edge that took it.
  // tvalid stays high so back-to-back words need no extra assignment.
  task automatic send_event(input logic [2:0] kind, input logic stable,
                            input logic [ErrW-1:0] errs, input logic mac,
                            input logic isch, input logic voice);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, voice, isch, mac, errs, stable};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    step_lock_model(kind, stable, errs, mac, isch, voice);
  endtask

  // mostly stable evidence so the lock climbs, with enough noise to drop back;
  // sync errors cluster around the threshold so hits and misses both occur
  task automatic send_random_event();
    int pick;
    int hi;
    logic [2:0] kind;
    logic [ErrW-1:0] errs;
    pick = $urandom_range(0, 99);
    if (pick < 20) kind = KIND_CARRIER;
    else if (pick < 40) kind = KIND_TIMING;
    else if (pick < 65) kind = KIND_SYNC;
    else if (pick < 85) kind = KIND_EVIDENCE;
    else if (pick < 94) kind = KIND_FAILURE;
    else if (pick < 95) kind = KIND_LOST;
    else kind = ($urandom_range(0, 1) != 0) ? KindUndefHi : KindUndefLo;
    hi = int'(sync_thr_q) + 2;
    if (hi > 63) hi = 63;
    if ($urandom_range(0, 1) != 0) errs = ErrW'($urandom_range(0, hi));
    else errs = ErrW'($urandom);
    send_event(kind, $urandom_range(0, 7) != 0, errs, 1'($urandom), 1'($urandom),
               1'($urandom));
  endtask

  // stop offering and let every predicted word come back, plus pipeline slack
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (lock_expect_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // only called with the block drained
  task automatic write_threshold(input logic [ErrW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sync_thr_q  = value;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // walk cold -> acquiring -> tracking soft -> cold, touching ignored
  // kinds, empty evidence, score floors and the threshold boundary on the way
  task automatic test_directed_walk();
    send_event(KindUndefLo, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1);
    send_event(KindUndefHi, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
    send_event(KIND_EVIDENCE, 1'b1, 6'd63, 1'b0, 1'b0, 1'b0);
    send_event(KIND_CARRIER, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) send_event(KIND_CARRIER, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 5; i++) send_event(KIND_TIMING, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1);
    // sync: at threshold, zero, worst case miss, then at threshold and one above it
    send_event(KIND_SYNC, 1'b0, SyncThrRst, 1'b0, 1'b0, 1'b0);
    send_event(KIND_SYNC, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
    send_event(KIND_SYNC, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1);
    send_event(KIND_SYNC, 1'b0, SyncThrRst, 1'b0, 1'b0, 1'b0);
    send_event(KIND_SYNC, 1'b0, SyncThrRst + 6'd1, 1'b0, 1'b0, 1'b0);
    send_event(KIND_EVIDENCE, 1'b0, 6'd0, 1'b1, 1'b1, 1'b1);
    send_event(KIND_EVIDENCE, 1'b0, 6'd0, 1'b1, 1'b1, 1'b1);
    send_event(KIND_SYNC, 1'b0, 6'd1, 1'b0, 1'b0, 1'b0);
    send_event(KIND_SYNC, 1'b0, 6'd2, 1'b0, 1'b0, 1'b0);
    send_event(KIND_FAILURE, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1);
    send_event(KindUndefHi, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
    send_event(KIND_EVIDENCE, 1'b0, 6'd0, 1'b0, 1'b0, 1'b1);
    send_event(KIND_LOST, 1'b1, 6'd63, 1'b1, 1'b1, 1'b1);
    wait_drained();
  endtask

  // both threshold extremes: at zero only a perfect sync hits,
  // at the top every error count hits
  task automatic test_sync_threshold_edges();
    write_threshold(6'd0);
    send_event(KIND_SYNC, 1'b1, 6'd0, 1'b0, 1'b0, 1'b0);
    send_event(KIND_SYNC, 1'b1, 6'd1, 1'b0, 1'b0, 1'b0);
    wait_drained();
    write_threshold(6'd63);
    send_event(KIND_SYNC, 1'b0, 6'd63, 1'b1, 1'b0, 1'b0);
    send_event(KIND_SYNC, 1'b0, 6'd62, 1'b0, 1'b1, 1'b0);
    wait_drained();
    write_threshold(SyncThrRst);
  endtask

  // carrier, timing and sync scores pinned at 100, then both run counters saturated at 255;
  // the miss run parks the lock in recovering until a hit clears it
  task automatic test_run_saturation();
    for (int i = 0; i < 27; i++) send_event(KIND_CARRIER, 1'b1, ErrW'($urandom), 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 27; i++) send_event(KIND_TIMING, 1'b1, ErrW'($urandom), 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) send_event(KIND_SYNC, 1'b0, 6'd0, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 262; i++) begin
      send_event(KIND_SYNC, 1'($urandom), 6'd63, 1'($urandom), 1'($urandom), 1'($urandom));
      send_event(KIND_FAILURE, 1'($urandom), ErrW'($urandom), 1'b0, 1'b0, 1'b0);
    end
    send_event(KIND_SYNC, 1'b0, 6'd3, 1'b0, 1'b0, 1'b0);
    send_event(KIND_EVIDENCE, 1'b0, 6'd0, 1'b0, 1'b1, 1'b0);
    wait_drained();
  endtask

  // sink holds off for a long stretch while the source keeps pushing,
  // so the block's two-word buffer fills and s_axis_tready must drop
  task automatic test_output_backpressure();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    hold_off_req  = 60;
    for (int i = 0; i < 24; i++) send_random_event();
    wait_drained();
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
  endtask

  // random event streams under several threshold settings
  task automatic test_random_events();
    logic [ErrW-1:0] thr_set[4];
    thr_set[0] = SyncThrRst;
    thr_set[1] = ErrW'($urandom_range(0, 63));
    thr_set[2] = 6'd0;
    thr_set[3] = 6'd63;
    for (int p = 0; p < 4; p++) begin
      write_threshold(thr_set[p]);
      for (int i = 0; i < 220; i++) send_random_event();
      wait_drained();
    end
  endtask

  // closing stretch at full rate on both sides
  task automatic test_no_idle_stream();
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    write_threshold(ErrW'($urandom_range(1, 62)));
    for (int i = 0; i < 150; i++) send_random_event();
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= '0;
    s_axis_tdata  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_walk();
    test_sync_threshold_edges();
    test_run_saturation();
    test_output_backpressure();
    test_random_events();
    test_no_idle_stream();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
